// ===== rtl/qls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the quadrature layer selector.
// Used by qls_mod_unit and quadrature_layer_selector; depends on nothing else.

package qls_pkg;

  // Timestamp arithmetic width; differences wrap modulo 2^TIME_BITS.
  localparam int TIME_BITS = 32;
  // Width of the external timestamp and of the fast-window register.
  localparam int TS_IN_BITS = 32;
  // Compare width wide enough for both the time difference and the window.
  localparam int CMP_BITS = (TIME_BITS > TS_IN_BITS) ? TIME_BITS : TS_IN_BITS;

  // Layer and step widths.
  localparam int LAYER_BITS = 8;
  localparam int COUNT_BITS = 9;
  localparam int STEP_BITS  = 7;
  // Magnitude of layer plus step, at most 382, fits nine bits.
  localparam int MAG_BITS   = 9;

  // Configuration register indexes.
  localparam logic [1:0] REG_FAST_WINDOW = 2'd0;
  localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
  localparam logic [1:0] REG_LAYER_COUNT = 2'd2;

  // Handshake between the top level and the modulo unit.
  typedef struct packed {
    logic busy;
    logic done;
  } qls_mod_status_t;

  // Transition code {previous A, previous B, A, B} to a count of -1, 0 or +1.
  function automatic logic signed [1:0] trans_delta(input logic [3:0] code);
    logic signed [1:0] d;
    d = 2'sd0;
    case (code)
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
      default:                  d = 2'sd0;
    endcase
    return d;
  endfunction

  // Layer count in use: zero or anything above 256 means 256.
  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] lc);
    logic [COUNT_BITS-1:0] c;
    c = lc;
    if (lc == '0 || lc > 9'd256) begin
      c = 9'd256;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qls_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Iterative true-modulo unit: restoring remainder one bit per cycle, then sign fix.
// Depends on qls_pkg.

module qls_mod_unit
  import qls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [MAG_BITS-1:0]   mag_in,
  input  wire logic                  neg_in,
  input  wire logic [COUNT_BITS-1:0] cnt_in,
  output qls_mod_status_t            status,
  output logic [LAYER_BITS-1:0]      result
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_DIV  = 2'd1;
  localparam logic [1:0] M_FIX  = 2'd2;

  logic [1:0]            mstate;
  logic [MAG_BITS-1:0]   mag;
  logic                  neg;
  logic [COUNT_BITS-1:0] cnt;
  logic [3:0]            bit_idx;
  logic [COUNT_BITS:0]   rem;
  logic                  done;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   fixed;

  // Shared subtract and compare stage.
  always_comb begin
    rem_shift = {rem[COUNT_BITS-1:0], mag[bit_idx]};
    trial     = rem_shift - {1'b0, cnt};
    fixed     = {1'b0, cnt} - rem;
  end

  // Sequencer: nine remainder steps, then a negative-dividend correction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (mstate)
        M_IDLE: begin
          if (start) begin
            mag     <= mag_in;
            neg     <= neg_in;
            cnt     <= cnt_in;
            rem     <= '0;
            bit_idx <= 4'(MAG_BITS - 1);
            mstate  <= M_DIV;
          end
        end
        M_DIV: begin
          if (rem_shift >= {1'b0, cnt}) begin
            rem <= trial;
          end else begin
            rem <= rem_shift;
          end
          if (bit_idx == 4'd0) begin
            mstate <= M_FIX;
          end else begin
            bit_idx <= bit_idx - 4'd1;
          end
        end
        M_FIX: begin
          if (neg && rem != '0) begin
            result <= fixed[LAYER_BITS-1:0];
          end else begin
            result <= rem[LAYER_BITS-1:0];
          end
          done   <= 1'b1;
          mstate <= M_IDLE;
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

  assign status.busy = (mstate != M_IDLE);
  assign status.done = done;

endmodule

`default_nettype wire

// ===== rtl/quadrature_layer_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the quadrature layer selector: decoder, step choice and output register.
// Depends on qls_pkg and qls_mod_unit.
//
// Each input transaction carries one sample of phases A and B with a microsecond
// timestamp and yields exactly one output transaction with the current layer and
// the signed step applied. A sample that does not complete a detent goes to the done
// state, from which the output register is loaded once it is free, and the next
// sample can be accepted after that. A sample that moves the layer starts the shared
// modulo unit, which loads its operands, resolves the remainder one bit per step and
// then corrects the sign; the layer is written back from its result, then the output
// register is loaded once it is free, and only then can the next sample be accepted.
// s_tready is low while a sample is being worked on; a finished result may wait in
// the output register while the next sample is accepted, and that next sample then
// holds s_tready low until the output register is free. Configuration writes take
// effect at once and should be made only while the block is idle.

module quadrature_layer_selector
  import qls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream. tdata: [0] phase_a, [1] phase_b, [33:2] time_us, [39:34] zero.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,
  // Output stream. tdata: [7:0] layer, [15:8] step_taken (signed).
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers.
  logic [TS_IN_BITS-1:0] fast_window_us;
  logic [STEP_BITS-1:0]  step_size;
  logic [COUNT_BITS-1:0] num_layers;

  // Decoder state.
  logic [1:0]              state;
  logic [1:0]              last_phases;
  logic signed [3:0]       accumulator;
  logic [TIME_BITS-1:0]    last_up_time;
  logic [TIME_BITS-1:0]    last_down_time;
  logic [LAYER_BITS-1:0]   layer_index;
  logic signed [7:0]       step_reg;

  // Input fields.
  logic                  phase_a;
  logic                  phase_b;
  logic [TS_IN_BITS-1:0] time_us;
  logic [TIME_BITS-1:0]  now;
  logic                  accept;

  // Decode and step choice.
  logic [1:0]            now_pair;
  logic signed [3:0]     acc_sum;
  logic                  move_up;
  logic                  move_down;
  logic [TIME_BITS-1:0]  delta_t;
  logic                  fast;
  logic [STEP_BITS-1:0]  mag;
  logic signed [7:0]     step_val;
  logic signed [9:0]     sum;
  logic [MAG_BITS-1:0]   sum_mag;

  qls_mod_status_t       mod_status;
  logic [LAYER_BITS-1:0] mod_result;

  assign phase_a  = s_tdata[0];
  assign phase_b  = s_tdata[1];
  assign time_us  = s_tdata[33:2];
  assign now      = TIME_BITS'(time_us);
  assign s_tready = (state == ST_IDLE) && !mod_status.busy;
  assign accept   = s_tvalid && s_tready;

  // Transition decode, detent detection and fast-step test.
  always_comb begin
    now_pair  = {phase_a, phase_b};
    acc_sum   = accumulator + 4'(trans_delta({last_phases, now_pair}));
    move_up   = (acc_sum > 4'sd3);
    move_down = (acc_sum < -4'sd3);
    if (move_up) begin
      delta_t = now - last_up_time;
    end else begin
      delta_t = now - last_down_time;
    end
    fast = (CMP_BITS'(delta_t) < CMP_BITS'(fast_window_us));
    mag  = fast ? step_size : STEP_BITS'(1);
    if (move_up) begin
      step_val = $signed({1'b0, mag});
    end else if (move_down) begin
      step_val = -$signed({1'b0, mag});
    end else begin
      step_val = 8'sd0;
    end
    sum = $signed({2'b00, layer_index}) + 10'(step_val);
    if (sum < 10'sd0) begin
      sum_mag = MAG_BITS'(-sum);
    end else begin
      sum_mag = MAG_BITS'(sum);
    end
  end

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_window_us <= 32'd50000;
      step_size      <= 7'd1;
      num_layers     <= 9'd8;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FAST_WINDOW: fast_window_us <= cfg_wdata;
        REG_STEP_SIZE:   step_size      <= cfg_wdata[STEP_BITS-1:0];
        REG_LAYER_COUNT: num_layers     <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared modulo unit wraps the layer.
  qls_mod_unit u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && (move_up || move_down)),
    .mag_in (sum_mag),
    .neg_in (sum < 10'sd0),
    .cnt_in (eff_count(num_layers)),
    .status (mod_status),
    .result (mod_result)
  );

  // Sequencer and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_phases    <= 2'b11;
      accumulator    <= 4'sd0;
      last_up_time   <= '0;
      last_down_time <= '0;
      layer_index    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // The output register empties on acceptance unless it is reloaded below.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_phases <= now_pair;
            step_reg    <= step_val;
            if (move_up || move_down) begin
              accumulator <= 4'sd0;
              if (move_up) begin
                last_up_time <= now;
              end else begin
                last_down_time <= now;
              end
              state <= ST_CALC;
            end else begin
              accumulator <= acc_sum;
              state       <= ST_DONE;
            end
          end
        end
        ST_CALC: begin
          if (mod_status.done) begin
            layer_index <= mod_result;
            state       <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Load the output register once it is free.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {step_reg, layer_index};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/quadrature_layer_selector_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_layer_selector: feeds encoder samples, predicts
// the layer and signed step of every sample and checks each output transaction in order.
// Depends on qls_pkg and on the quadrature_layer_selector RTL.

module quadrature_layer_selector_test;
  import qls_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;
  localparam int MAX_REPORTS = 10;

  // One encoder sample and one layer report, laid out as on the streams.
  typedef struct packed {
    logic [31:0] time_us;
    logic        phase_b;
    logic        phase_a;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] step_taken;
    logic [7:0]        layer;
  } layer_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [0] phase_a, [1] phase_b, [33:2] time_us, [39:34] zero.
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] layer, [15:8] step_taken (signed).
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_FAST_WINDOW;
  logic [31:0] cfg_wdata = '0;

  // Samples waiting to be offered and layer reports still owed by the block.
  sample_t    pending[$];
  layer_out_t layer_due[$];
  sample_t    offer;
  logic       offer_taken = 1'b0;

  // Predicted block state and register copies.
  logic [1:0]  prev_pair;
  int          detent_count;
  logic [31:0] last_up_us;
  logic [31:0] last_down_us;
  logic [7:0]  cur_layer;
  logic [31:0] fast_window;
  logic [6:0]  fast_step;
  logic [8:0]  layer_total;

  // Count per transition code {previous A, previous B, A, B}.
  int detent_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  // Stimulus generator position.
  logic [1:0]  gen_pair;
  logic [31:0] gen_time;

  // Flow control.
  logic idling_on = 1'b1;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   send_gap = 0;
  int   mismatches = 0;
  int   cycles = 0;

  quadrature_layer_selector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Works out the layer and step that one sample produces and advances the state.
  function automatic layer_out_t next_layer(input sample_t s);
    logic [1:0]  pair;
    logic [3:0]  code;
    logic [31:0] elapsed;
    int          step;
    int          span;
    int          sum;
    int          rem;
    layer_out_t  r;
    pair = {s.phase_a, s.phase_b};
    code = {prev_pair, pair};
    prev_pair = pair;
    detent_count += detent_delta[code];
    step = 0;
    if (detent_count > 3) begin
      elapsed = s.time_us - last_up_us;
      step = (elapsed < fast_window) ? int'(fast_step) : 1;
      last_up_us = s.time_us;
    end else if (detent_count < -3) begin
      elapsed = s.time_us - last_down_us;
      step = (elapsed < fast_window) ? -int'(fast_step) : -1;
      last_down_us = s.time_us;
    end
    if (detent_count > 3 || detent_count < -3) begin
      // A count of zero or above 256 means 256; the remainder is kept non-negative.
      span = (layer_total == 9'd0 || layer_total > 9'd256) ? 256 : int'(layer_total);
      sum = int'(cur_layer) + step;
      rem = sum % span;
      if (rem < 0) begin
        rem += span;
      end
      cur_layer = rem[7:0];
      detent_count = 0;
    end
    r.layer = cur_layer;
    r.step_taken = step[7:0];
    return r;
  endfunction

  // Next {A,B} pair one quarter of a detent on, in either direction.
  function automatic logic [1:0] quarter_turn(input logic [1:0] p, input logic up);
    logic [1:0] n;
    case (p)
      2'd3:    n = up ? 2'd1 : 2'd2;
      2'd1:    n = up ? 2'd0 : 2'd3;
      2'd0:    n = up ? 2'd2 : 2'd1;
      default: n = up ? 2'd3 : 2'd0;
    endcase
    return n;
  endfunction

  task automatic push_sample(input logic a, input logic b, input logic [31:0] t);
    sample_t s;
    s.phase_a = a;
    s.phase_b = b;
    s.time_us = t;
    pending.push_back(s);
  endtask

  task automatic push_quarter(input logic up, input logic [31:0] dt);
    gen_pair = quarter_turn(gen_pair, up);
    gen_time += dt;
    push_sample(gen_pair[1], gen_pair[0], gen_time);
  endtask

  // Mostly clean rotation at varied speeds, with bounce, odd levels and time jumps.
  task automatic push_motion(input int n);
    int   made;
    int   kind;
    int   turns;
    int   q;
    logic up;
    logic brisk;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      up = 1'($urandom_range(0, 1));
      if (kind < 70) begin
        brisk = 1'($urandom_range(0, 1));
        turns = $urandom_range(1, 5);
        for (q = 0; q < 4 * turns; q++) begin
          push_quarter(up, brisk ? $urandom_range(0, 4000) : $urandom_range(20000, 300000));
          made++;
        end
      end else if (kind < 82) begin
        // Contact bounce: a quarter forward and straight back.
        push_quarter(up, $urandom_range(0, 50));
        push_quarter(!up, $urandom_range(0, 50));
        made += 2;
      end else if (kind < 92) begin
        // Arbitrary levels, including repeats and jumps across both phases.
        gen_pair = 2'($urandom_range(0, 3));
        gen_time += $urandom_range(0, 100000);
        push_sample(gen_pair[1], gen_pair[0], gen_time);
        made++;
      end else begin
        // The timestamp leaps anywhere in its range.
        gen_time = $urandom();
        push_sample(gen_pair[1], gen_pair[0], gen_time);
        made++;
      end
    end
  endtask

  // Waits until every sample is taken and answered, then lets the block settle.
  task automatic wait_idle();
    while (pending.size() != 0 || s_tvalid || layer_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FAST_WINDOW: fast_window = val;
      REG_STEP_SIZE:   fast_step = val[6:0];
      REG_LAYER_COUNT: layer_total = val[8:0];
      default:         ;
    endcase
  endtask

  task automatic run_phase(input logic [31:0] window, input logic [31:0] step,
                           input logic [31:0] count, input int n, input logic long_hold);
    wait_idle();
    set_reg(REG_FAST_WINDOW, window);
    set_reg(REG_STEP_SIZE, step);
    set_reg(REG_LAYER_COUNT, count);
    if (long_hold) begin
      hold_req = 1'b1;
    end
    push_motion(n);
  endtask

  task automatic report(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Sender: offers the next pending sample once the current one is taken, with random gaps between samples.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || offer_taken)) begin
      offer_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        offer = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, offer.time_us, offer.phase_b, offer.phase_a};
        if (idling_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 10);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Input transaction: predict the report it owes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      layer_due.push_back(next_layer(offer));
      offer_taken = 1'b1;
    end
  end

  // Receiver: random stalls in bursts, plus one long hold when asked.
  always @(negedge clk) begin
    logic ready_next;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    m_tready <= ready_next;
  end

  // Output transaction: compare with the oldest prediction.
  always @(posedge clk) begin
    layer_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (layer_due.size() == 0) begin
        report("unrequested result", 0, m_tdata);
      end else begin
        want = layer_due.pop_front();
        if (m_tdata[7:0] != want.layer) begin
          report("layer", want.layer, m_tdata[7:0]);
        end
        if (m_tdata[15:8] != want.step_taken) begin
          report("step_taken", want.step_taken, $signed(m_tdata[15:8]));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] tour;
    int          i;
    prev_pair = 2'd3;
    detent_count = 0;
    last_up_us = '0;
    last_down_us = '0;
    cur_layer = '0;
    fast_window = 32'd50000;
    fast_step = 7'd1;
    layer_total = 9'd8;
    gen_pair = 2'd3;
    gen_time = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every transition code once at reset settings: a full detent down, then one up
    // through the illegal jumps, at both timestamp extremes.
    tour = {2'd3, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd3,
            2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3};
    for (i = 0; i < 16; i++) begin
      gen_pair = tour[31 - 2 * i -: 2];
      gen_time = (i < 8) ? 32'h0 : 32'hFFFF_FFFF;
      push_sample(gen_pair[1], gen_pair[0], gen_time);
    end
    wait_idle();

    // Fast detection across the timestamp wrap going up, then a fast detent down.
    set_reg(REG_FAST_WINDOW, 32'd50000);
    set_reg(REG_STEP_SIZE, 32'd9);
    set_reg(REG_LAYER_COUNT, 32'd256);
    gen_time = 32'hFFFF_FFF0;
    for (i = 0; i < 4; i++) push_quarter(1'b1, 32'd0);
    gen_time = 32'h0000_000C;
    for (i = 0; i < 4; i++) push_quarter(1'b1, 32'd1);
    for (i = 0; i < 4; i++) push_quarter(1'b0, 32'd1);

    // Window never met, widest step and count.
    run_phase(32'd0, 32'd127, 32'd256, 175, 1'b0);
    // Window always met, a single layer.
    run_phase(32'hFFFF_FFFF, 32'd127, 32'd1, 175, 1'b0);
    // Zero step with a zero count standing for 256.
    run_phase(32'd50000, 32'd0, 32'd0, 175, 1'b0);
    // Oversized count, with the receiver held off long enough to back up the input.
    run_phase(32'd200000, 32'd5, 32'd511, 175, 1'b1);
    // Large steps to reach high layers, then shrink the count beneath them.
    run_phase(32'hFFFF_FFFF, 32'd127, 32'd256, 175, 1'b0);
    run_phase(32'd100000, 32'd3, 32'd5, 175, 1'b0);
    for (i = 0; i < 3; i++) begin
      run_phase($urandom_range(0, 300000), $urandom_range(0, 127), $urandom_range(1, 256),
                175, 1'b0);
    end
    // Closing stretch at full rate on both sides.
    wait_idle();
    idling_on = 1'b0;
    run_phase(32'd20000, 32'd2, 32'd200, 175, 1'b0);
    wait_idle();

    if (mismatches == 0 && layer_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qls_pkg.sv
rtl/qls_mod_unit.sv
rtl/quadrature_layer_selector.sv
bench/quadrature_layer_selector_test.sv
